>>> src/buddy_allocator_fit_modes_macros.svh
// assertion macros shared by the allocator rtl
// expects clk and rst_n in the scope of each use
`ifndef BUDDY_ALLOCATOR_FIT_MODES_MACROS_SVH
`define BUDDY_ALLOCATOR_FIT_MODES_MACROS_SVH

// same-cycle implication
`define BAFM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BAFM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/bafm_pkg.sv
// shared constants for the buddy allocator
// no dependencies
package bafm_pkg;

  // payload widths
  localparam int SIZE_W  = 16;
  localparam int ADDR_W  = 16;
  localparam int ORD_W   = 5;
  localparam int FREE_W  = 17;
  localparam int ENT_W   = 6;

  // configuration register indexes
  localparam logic CFG_FIT_MODE   = 1'b0;
  localparam logic CFG_POOL_ORDER = 1'b1;

  // fit modes, anything else is first fit
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // request codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status
  localparam logic ST_DONE = 1'b0;
  localparam logic ST_FAIL = 1'b1;

endpackage

>>> src/bafm_if.sv
// request and result channels of the allocator
// depends on bafm_pkg
interface bafm_in_if import bafm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [SIZE_W-1:0] item_size;
  logic [SIZE_W-1:0] item_count;
  logic [ADDR_W-1:0] free_address;

  modport source (output valid, cmd, item_size, item_count, free_address, input ready);
  modport sink   (input valid, cmd, item_size, item_count, free_address, output ready);
endinterface

interface bafm_out_if import bafm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic [ADDR_W-1:0] address;
  logic [ORD_W-1:0]  block_order;
  logic [FREE_W-1:0] free_bytes;

  modport source (output valid, status, address, block_order, free_bytes, input ready);
  modport sink   (input valid, status, address, block_order, free_bytes, output ready);
endinterface

>>> src/bafm_ram.sv
// generic single-port ram with registered read
// no dependencies
module bafm_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/buddy_allocator_fit_modes.sv
// Buddy allocator over a pool of 2^pool_order bytes.
// Requests arrive on in_ch (valid/ready): allocate (cmd 0) takes item_size and
// item_count, free (cmd 1) takes a free_address returned earlier. Each request
// gives exactly one result on out_ch: status, address, block_order, free_bytes.
// The block table, one 6-bit entry per 2^MIN_ORDER-byte unit, sits in a
// single-port ram; each step makes at most one ram access.
// Allocate: multiply, search the smallest order, scan the table (ending early
// on first fit), split one level per step, mark the block, then hand over.
// Free: validate and read the entry, mark it free, then per merge level read
// the buddy, check it and write the merged entry. One request is in work at a
// time; the ram port sets the rate.
// The result sits in an output register; the next request is taken while it
// waits. A stalled receiver only holds the block once a second result is done.
// Reset and any pool_order write rebuild all 2^(MAX_ORDER - MIN_ORDER) table
// entries in a clearing pass; requests wait, configuration writes are taken.
// The user writes configuration only while idle; the block does not check it.
`include "buddy_allocator_fit_modes_macros.svh"

module buddy_allocator_fit_modes import bafm_pkg::*; #(
  parameter int MAX_ORDER    = 16,
  parameter int MIN_ORDER    = 5,
  parameter int HEADER_BYTES = 19
) (
  input  logic         clk,
  input  logic         rst_n,
  bafm_in_if.sink      in_ch,
  bafm_out_if.source   out_ch,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [4:0]   cfg_data
);

  localparam int IDX_W = MAX_ORDER - MIN_ORDER;
  localparam int UNITS = 1 << IDX_W;
  localparam int CNT_W = IDX_W + 1;
  localparam int FB_W  = MAX_ORDER + 1;
  localparam int OFF_W = (MAX_ORDER > ADDR_W) ? MAX_ORDER : ADDR_W;
  localparam int NEED_W = 2 * SIZE_W + 1;

  // state codes
  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ORD   = 4'd3;
  localparam logic [3:0] S_SCAN  = 4'd4;
  localparam logic [3:0] S_SPLIT = 4'd5;
  localparam logic [3:0] S_MARK  = 4'd6;
  localparam logic [3:0] S_FRD   = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_BRD   = 4'd9;
  localparam logic [3:0] S_BCHK  = 4'd10;
  localparam logic [3:0] S_MW    = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]        state_r, state_nxt;
  logic [1:0]        fit_mode_r, fit_mode_nxt;
  logic [4:0]        pool_order_r, pool_order_nxt;
  logic [SIZE_W-1:0] size_r, size_nxt, count_r, count_nxt;
  logic              cmd_r, cmd_nxt;
  logic [ADDR_W-1:0] faddr_r, faddr_nxt;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [4:0]        ord_r, ord_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  best_r, best_nxt;
  logic [4:0]        best_ord_r, best_ord_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt, bud_r, bud_nxt;
  logic [4:0]        o_r, o_nxt;
  logic [FB_W-1:0]   free_cnt_r, free_cnt_nxt;
  logic              res_st_r, res_st_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [4:0]        res_ord_r, res_ord_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              out_st_r, out_st_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [4:0]        out_ord_r, out_ord_nxt;
  logic [FREE_W-1:0] out_free_r, out_free_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_addr;
  logic [ENT_W-1:0]  ram_wdata, ram_rdata;

  logic [4:0]        eff_p;
  logic [CNT_W-1:0]  units;
  logic [FB_W-1:0]   pool_bytes;
  logic [OFF_W-1:0]  off;
  logic [4:0]        e_ord, nb;
  logic              e_busy, e_ok, take, first_mode, out_free_slot;
  logic [31:0]       prod;

  bafm_ram #(.WIDTH(ENT_W), .DEPTH(UNITS)) u_table (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // effective pool order and derived sizes
  always_comb begin
    if (pool_order_r < 5'(MIN_ORDER)) begin
      eff_p = 5'(MIN_ORDER);
    end else if (pool_order_r > 5'(MAX_ORDER)) begin
      eff_p = 5'(MAX_ORDER);
    end else begin
      eff_p = pool_order_r;
    end
  end
  assign units      = CNT_W'(1) << (eff_p - 5'(MIN_ORDER));
  assign pool_bytes = FB_W'(1) << eff_p;

  // entry decode and fit choice
  assign e_ord      = ram_rdata[4:0];
  assign e_busy     = ram_rdata[5];
  assign e_ok       = (e_ord != 5'd0) && !e_busy && (e_ord >= ord_r);
  assign first_mode = (fit_mode_r != FIT_BEST) && (fit_mode_r != FIT_WORST);
  assign take       = rd_vld_r && e_ok &&
                      (!found_r || (fit_mode_r == FIT_BEST && e_ord < best_ord_r) ||
                       (fit_mode_r == FIT_WORST && e_ord > best_ord_r));
  assign nb         = best_ord_r - 5'd1;
  assign off        = OFF_W'(faddr_r) - OFF_W'(HEADER_BYTES);
  assign prod       = 32'(size_r) * 32'(count_r);
  assign out_free_slot = !out_vld_r || out_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt = state_r;     fit_mode_nxt = fit_mode_r; pool_order_nxt = pool_order_r;
    size_nxt = size_r;       count_nxt = count_r;       cmd_nxt = cmd_r;
    faddr_nxt = faddr_r;     need_nxt = need_r;         ord_nxt = ord_r;
    cnt_nxt = cnt_r;         rd_vld_nxt = 1'b0;         rd_idx_nxt = rd_idx_r;
    found_nxt = found_r;     best_nxt = best_r;         best_ord_nxt = best_ord_r;
    idx_nxt = idx_r;         bud_nxt = bud_r;           o_nxt = o_r;
    free_cnt_nxt = free_cnt_r;
    res_st_nxt = res_st_r;   res_addr_nxt = res_addr_r; res_ord_nxt = res_ord_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    out_st_nxt = out_st_r;   out_addr_nxt = out_addr_r; out_ord_nxt = out_ord_r;
    out_free_nxt = out_free_r;
    ram_we = 1'b0;
    ram_addr = cnt_r[IDX_W-1:0];
    ram_wdata = '0;

    unique case (state_r)
      S_CLR: begin
        ram_we = 1'b1;
        ram_wdata = (cnt_r == '0) ? {1'b0, eff_p} : '0;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(UNITS - 1)) begin
          free_cnt_nxt = pool_bytes;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_ch.cmd;
          size_nxt = in_ch.item_size;
          count_nxt = in_ch.item_count;
          faddr_nxt = in_ch.free_address;
          state_nxt = (in_ch.cmd == CMD_FREE) ? S_FRD : S_MUL;
        end
      end
      S_MUL: begin
        need_nxt = NEED_W'(prod) + NEED_W'(HEADER_BYTES);
        ord_nxt = 5'(MIN_ORDER);
        state_nxt = S_ORD;
      end
      // smallest order that holds the request
      S_ORD: begin
        if (ord_r > eff_p) begin
          res_st_nxt = ST_FAIL; res_addr_nxt = '0; res_ord_nxt = '0;
          state_nxt = S_DONE;
        end else if ((34'(1) << ord_r) >= 34'(need_r)) begin
          cnt_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end else begin
          ord_nxt = ord_r + 5'd1;
        end
      end
      // one table read per cycle, evaluated in the cycle after it is issued
      S_SCAN: begin
        if (cnt_r < units) begin
          ram_addr = cnt_r[IDX_W-1:0];
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = cnt_r[IDX_W-1:0];
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (take) begin
          found_nxt = 1'b1;
          best_nxt = rd_idx_r;
          best_ord_nxt = e_ord;
        end
        if (take && first_mode) begin
          state_nxt = S_SPLIT;
        end else if (!rd_vld_r && cnt_r >= units) begin
          if (found_r) begin
            state_nxt = S_SPLIT;
          end else begin
            res_st_nxt = ST_FAIL; res_addr_nxt = '0; res_ord_nxt = '0;
            state_nxt = S_DONE;
          end
        end
      end
      // free the upper half, one level per cycle
      S_SPLIT: begin
        if (best_ord_r > ord_r) begin
          ram_we = 1'b1;
          ram_addr = best_r + (IDX_W'(1) << (nb - 5'(MIN_ORDER)));
          ram_wdata = {1'b0, nb};
          best_ord_nxt = nb;
        end else begin
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        ram_we = 1'b1;
        ram_addr = best_r;
        ram_wdata = {1'b1, ord_r};
        free_cnt_nxt = free_cnt_r - (FB_W'(1) << ord_r);
        res_st_nxt = ST_DONE;
        res_addr_nxt = ADDR_W'(32'({best_r, {MIN_ORDER{1'b0}}}) + 32'(HEADER_BYTES));
        res_ord_nxt = ord_r;
        state_nxt = S_DONE;
      end
      // validate free address and read its entry
      S_FRD: begin
        idx_nxt = off[MAX_ORDER-1:MIN_ORDER];
        ram_addr = off[MAX_ORDER-1:MIN_ORDER];
        if (faddr_r < ADDR_W'(HEADER_BYTES) || 32'(off) >= 32'(pool_bytes) ||
            off[MIN_ORDER-1:0] != '0) begin
          res_st_nxt = ST_FAIL; res_addr_nxt = '0; res_ord_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        if (e_ord == 5'd0 || !e_busy) begin
          res_st_nxt = ST_FAIL; res_addr_nxt = '0; res_ord_nxt = '0;
          state_nxt = S_DONE;
        end else begin
          ram_we = 1'b1;
          ram_addr = idx_r;
          ram_wdata = {1'b0, e_ord};
          o_nxt = e_ord;
          free_cnt_nxt = free_cnt_r + (FB_W'(1) << e_ord);
          state_nxt = S_BRD;
        end
      end
      // merge with the buddy while it is free at the same order
      S_BRD: begin
        bud_nxt = idx_r ^ (IDX_W'(1) << (o_r - 5'(MIN_ORDER)));
        ram_addr = bud_nxt;
        if (o_r < eff_p) begin
          state_nxt = S_BCHK;
        end else begin
          res_st_nxt = ST_DONE;
          res_addr_nxt = ADDR_W'({idx_r, {MIN_ORDER{1'b0}}});
          res_ord_nxt = o_r;
          state_nxt = S_DONE;
        end
      end
      S_BCHK: begin
        if (ram_rdata == {1'b0, o_r}) begin
          ram_we = 1'b1;
          ram_addr = (bud_r < idx_r) ? idx_r : bud_r;
          ram_wdata = '0;
          idx_nxt = (bud_r < idx_r) ? bud_r : idx_r;
          o_nxt = o_r + 5'd1;
          state_nxt = S_MW;
        end else begin
          res_st_nxt = ST_DONE;
          res_addr_nxt = ADDR_W'({idx_r, {MIN_ORDER{1'b0}}});
          res_ord_nxt = o_r;
          state_nxt = S_DONE;
        end
      end
      S_MW: begin
        ram_we = 1'b1;
        ram_addr = idx_r;
        ram_wdata = {1'b0, o_r};
        state_nxt = S_BRD;
      end
      // hand the result to the output register
      S_DONE: begin
        if (out_free_slot) begin
          out_vld_nxt = 1'b1;
          out_st_nxt = res_st_r;
          out_addr_nxt = res_addr_r;
          out_ord_nxt = res_ord_r;
          out_free_nxt = FREE_W'(free_cnt_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLR;
    endcase

    // configuration writes
    if (cfg_we) begin
      priority if (cfg_index == CFG_FIT_MODE) begin
        fit_mode_nxt = cfg_data[1:0];
      end else if (cfg_index == CFG_POOL_ORDER) begin
        pool_order_nxt = cfg_data;
        cnt_nxt = '0;
        state_nxt = S_CLR;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      fit_mode_r   <= 2'd0;
      pool_order_r <= 5'd16;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      out_vld_r    <= 1'b0;
      free_cnt_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      fit_mode_r   <= fit_mode_nxt;
      pool_order_r <= pool_order_nxt;
      cnt_r        <= cnt_nxt;
      rd_vld_r     <= rd_vld_nxt;
      found_r      <= found_nxt;
      out_vld_r    <= out_vld_nxt;
      free_cnt_r   <= free_cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    size_r <= size_nxt;     count_r <= count_nxt;     cmd_r <= cmd_nxt;
    faddr_r <= faddr_nxt;   need_r <= need_nxt;       ord_r <= ord_nxt;
    rd_idx_r <= rd_idx_nxt; best_r <= best_nxt;       best_ord_r <= best_ord_nxt;
    idx_r <= idx_nxt;       bud_r <= bud_nxt;         o_r <= o_nxt;
    res_st_r <= res_st_nxt; res_addr_r <= res_addr_nxt; res_ord_r <= res_ord_nxt;
    out_st_r <= out_st_nxt; out_addr_r <= out_addr_nxt; out_ord_r <= out_ord_nxt;
    out_free_r <= out_free_nxt;
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.address     = out_addr_r;
  assign out_ch.block_order = out_ord_r;
  assign out_ch.free_bytes  = out_free_r;

  // checks
  `BAFM_ASSERT_IMP(a_free_bounded, state_r == S_IDLE && cmd_r == CMD_ALLOC, 32'(free_cnt_r) <= 32'(pool_bytes), "free byte count exceeds pool")
  `BAFM_ASSERT_IMP(a_write_states, ram_we, state_r == S_CLR || state_r == S_SPLIT || state_r == S_MARK || state_r == S_FCHK || state_r == S_BCHK || state_r == S_MW, "table written outside a write step")
  `BAFM_ASSERT_IMP(a_split_off_base, state_r == S_SPLIT && ram_we, ram_addr != best_r, "split overwrote the chosen block")
  `BAFM_ASSERT_IMP(a_done_order, out_vld_r && out_st_r == ST_DONE, out_ord_r >= 5'(MIN_ORDER), "successful result below minimum order")

endmodule

>>> bench/bafm_checker.sv
// result checker for the buddy allocator: watches request and result channels,
// keeps its own block table and compares every result. depends on bafm_pkg, bafm_if
module bafm_checker import bafm_pkg::*; #(
  parameter int MAX_ORDER    = 16,
  parameter int MIN_ORDER    = 5,
  parameter int HEADER_BYTES = 19
) (
  input  logic       clk,
  input  logic       rst_n,
  bafm_in_if         in_ch,
  bafm_out_if        out_ch,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [4:0] cfg_data,
  output int         fail_count,
  output int         pending
);

  localparam int UNITS = 1 << (MAX_ORDER - MIN_ORDER);

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] address;
    logic [ORD_W-1:0]  block_order;
    logic [FREE_W-1:0] free_bytes;
  } alloc_result_t;

  logic [ENT_W-1:0] blocks [UNITS];
  logic [FREE_W-1:0] free_total;
  logic [1:0] fit_sel;
  logic [4:0] pool_reg;
  alloc_result_t expected_q [$];

  assign pending = expected_q.size();

  function automatic int pool_eff();
    if (pool_reg < MIN_ORDER) return MIN_ORDER;
    if (pool_reg > MAX_ORDER) return MAX_ORDER;
    return pool_reg;
  endfunction

  task automatic rebuild_pool();
    int p;
    p = pool_eff();
    foreach (blocks[i]) blocks[i] = '0;
    blocks[0] = ENT_W'(p);
    free_total = FREE_W'(1 << p);
  endtask

  // allocate: size the block, pick by fit mode, split down
  function automatic alloc_result_t predict_alloc(logic [15:0] sz, logic [15:0] cnt);
    alloc_result_t r;
    longint need;
    int p, ord, units, best, best_ord, o;
    bit found;
    p = pool_eff();
    need = longint'(sz) * longint'(cnt) + HEADER_BYTES;
    ord = MIN_ORDER;
    found = 0;
    best = 0;
    best_ord = 0;
    r = '{ST_FAIL, '0, '0, free_total};
    while (ord < 40 && (64'd1 << ord) < need) ord++;
    if (ord > p) return r;
    units = 1 << (p - MIN_ORDER);
    for (int i = 0; i < units; i++) begin
      o = blocks[i][4:0];
      if (o == 0 || blocks[i][5] || o < ord) continue;
      if (!found || (fit_sel == FIT_BEST && o < best_ord) ||
          (fit_sel == FIT_WORST && o > best_ord)) begin
        found = 1;
        best = i;
        best_ord = o;
        if (fit_sel != FIT_BEST && fit_sel != FIT_WORST) break;
      end
    end
    if (!found) return r;
    while (best_ord > ord) begin
      best_ord--;
      blocks[best + (1 << (best_ord - MIN_ORDER))] = ENT_W'(best_ord);
    end
    blocks[best] = ENT_W'(ord) | 6'h20;
    free_total = free_total - FREE_W'(1 << ord);
    return '{ST_DONE, ADDR_W'((best << MIN_ORDER) + HEADER_BYTES), ORD_W'(ord), free_total};
  endfunction

  // free: validate address, then merge with free buddies
  function automatic alloc_result_t predict_free(logic [15:0] addr);
    alloc_result_t r;
    int p, off, idx, o, bud;
    p = pool_eff();
    r = '{ST_FAIL, '0, '0, free_total};
    if (addr < HEADER_BYTES) return r;
    off = addr - HEADER_BYTES;
    if (off >= (1 << p) || (off % (1 << MIN_ORDER)) != 0) return r;
    idx = off >> MIN_ORDER;
    o = blocks[idx][4:0];
    if (o == 0 || !blocks[idx][5]) return r;
    free_total = free_total + FREE_W'(1 << o);
    blocks[idx] = ENT_W'(o);
    while (o < p) begin
      bud = idx ^ (1 << (o - MIN_ORDER));
      if (bud >= UNITS || blocks[bud] != ENT_W'(o)) break;
      if (bud < idx) begin
        blocks[idx] = '0;
        idx = bud;
      end else begin
        blocks[bud] = '0;
      end
      o++;
      blocks[idx] = ENT_W'(o);
    end
    return '{ST_DONE, ADDR_W'(idx << MIN_ORDER), ORD_W'(o), free_total};
  endfunction

  // track config, predict on request, compare on result
  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst_n) begin
      fit_sel <= 2'd0;
      pool_reg = 5'd16;
      rebuild_pool();
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_FIT_MODE) begin
          fit_sel <= cfg_data[1:0];
        end else begin
          pool_reg = cfg_data;
          rebuild_pool();
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.cmd == CMD_ALLOC) expected_q.push_back(predict_alloc(in_ch.item_size,
                                                                    in_ch.item_count));
        else expected_q.push_back(predict_free(in_ch.free_address));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result address %0h", out_ch.address);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_ch.status !== exp_r.status || out_ch.address !== exp_r.address ||
              out_ch.block_order !== exp_r.block_order ||
              out_ch.free_bytes !== exp_r.free_bytes) begin
            fail_count <= fail_count + 1;
            if (out_ch.status !== exp_r.status)
              $error("status expected %0d got %0d", exp_r.status, out_ch.status);
            if (out_ch.address !== exp_r.address)
              $error("address expected %0h got %0h", exp_r.address, out_ch.address);
            if (out_ch.block_order !== exp_r.block_order)
              $error("block_order expected %0d got %0d", exp_r.block_order,
                     out_ch.block_order);
            if (out_ch.free_bytes !== exp_r.free_bytes)
              $error("free_bytes expected %0d got %0d", exp_r.free_bytes,
                     out_ch.free_bytes);
          end
        end
      end
    end
  end

endmodule

>>> bench/testbench.sv
// stimulus and verdict for the buddy allocator: directed and random
// allocate/free requests over several fit modes and pool sizes. depends on bafm_checker
module testbench;
  import bafm_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_FIT_MODE;
  logic [4:0] cfg_data = '0;
  int fail_count, pending;
  int send_idle_pct = 33, recv_idle_pct = 77;
  bit hold_recv = 0;
  logic [15:0] live_addrs [$];

  bafm_in_if  in_ch ();
  bafm_out_if out_ch ();

  buddy_allocator_fit_modes uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  bafm_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // collect addresses of successful results for later frees
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready && out_ch.status == ST_DONE &&
        out_ch.address >= 16'd19 && live_addrs.size() < 64)
      live_addrs.push_back(out_ch.address);
  end

  // receiver stalls
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_ALLOC;
    in_ch.item_size = '0;
    in_ch.item_count = '0;
    in_ch.free_address = '0;
  end

  // valid stays up after acceptance until the next idle cycle or the next request
  task automatic send_request(logic cmd, logic [15:0] sz, logic [15:0] cnt,
                              logic [15:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.item_size <= sz;
    in_ch.item_count <= cnt;
    in_ch.free_address <= addr;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic alloc_req(logic [15:0] sz, logic [15:0] cnt);
    send_request(CMD_ALLOC, sz, cnt, 16'($urandom));
  endtask

  task automatic free_req(logic [15:0] addr);
    send_request(CMD_FREE, 16'($urandom), 16'($urandom), addr);
  endtask

  // wait until idle, then write one register
  task automatic write_reg(logic idx, logic [4:0] val);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POOL_ORDER) live_addrs.delete();
  endtask

  // mostly small sizes, occasional huge ones, frees of live addresses
  task automatic random_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 45) alloc_req(16'($urandom_range(40)), 16'($urandom_range(12)));
      else if (k < 50) alloc_req(16'($urandom), 16'($urandom));
      else if (k < 88 && live_addrs.size() > 0) begin
        int j = $urandom_range(live_addrs.size() - 1);
        free_req(live_addrs[j]);
        live_addrs.delete(j);
      end else if (k < 94) free_req(16'($urandom));
      else alloc_req(16'($urandom_range(300)), 16'($urandom_range(4)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // directed: extremes, invalid frees, every fit mode
    alloc_req(16'd0, 16'd0);
    alloc_req(16'hFFFF, 16'hFFFF);
    alloc_req(16'd1, 16'd13);
    alloc_req(16'd1, 16'd14);
    alloc_req(16'd256, 16'd200);
    free_req(16'd0);
    free_req(16'd18);
    free_req(16'd20);
    free_req(16'hFFFF);
    free_req(16'd19);
    free_req(16'd19);
    free_req(16'd51);
    write_reg(CFG_POOL_ORDER, 5'd5);
    alloc_req(16'd1, 16'd13);
    alloc_req(16'd1, 16'd1);
    free_req(16'd19);
    write_reg(CFG_POOL_ORDER, 5'd2);
    alloc_req(16'd2, 16'd5);
    write_reg(CFG_POOL_ORDER, 5'd31);
    alloc_req(16'd100, 16'd100);
    write_reg(CFG_POOL_ORDER, 5'd9);
    write_reg(CFG_FIT_MODE, 5'(FIT_BEST));
    for (int i = 0; i < 4; i++) alloc_req(16'd10, 16'd2);
    write_reg(CFG_FIT_MODE, 5'(FIT_WORST));
    alloc_req(16'd3, 16'd3);
    write_reg(CFG_FIT_MODE, 5'd3);
    alloc_req(16'd3, 16'd3);
    // random, first idling profile
    random_phase(90);
    write_reg(CFG_FIT_MODE, 5'(FIT_BEST));
    write_reg(CFG_POOL_ORDER, 5'd10);
    send_idle_pct = 77;
    recv_idle_pct = 33;
    // long receiver hold so the block fills and stalls input
    fork
      begin
        hold_recv = 1;
        repeat (300) @(posedge clk);
        hold_recv = 0;
      end
      random_phase(10);
    join
    random_phase(80);
    write_reg(CFG_FIT_MODE, 5'(FIT_WORST));
    write_reg(CFG_POOL_ORDER, 5'd16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(85);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #12000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/bafm_pkg.sv
src/bafm_if.sv
src/bafm_ram.sv
src/buddy_allocator_fit_modes.sv
bench/bafm_checker.sv
bench/testbench.sv
